FILE: rtl/core/wde_pkg.sv
// shared types, constants and calendar tables for the weekend day enumerator
package wde_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WD_W    = 3;
    localparam int B_W     = 15;
    localparam int Q_W     = 8;
    localparam int K_W     = 16;
    localparam int PROD_W  = B_W + K_W;

    // reciprocal constants: floor(x / 100) = (x * K100) >> 21, floor(x / 7) = (x * K7) >> 18
    localparam logic [K_W-1:0] K100       = 16'd20972;
    localparam int             SHIFT100   = 21;
    localparam logic [K_W-1:0] K7         = 16'd37450;
    localparam int             SHIFT7     = 18;
    localparam int             Q7_W       = 12;

    localparam logic [B_W-1:0]     YEAR_BIAS = 15'd400;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [WD_W-1:0]    WD_SUN    = 3'd0;
    localparam logic [WD_W-1:0]    WD_SAT    = 3'd6;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
    } in_item_t;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [WD_W-1:0]  weekday;
        logic [DAY_W-1:0] month_length;
        logic             bad_month;
        logic             last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_YEAR,
        ST_DIV_BASE,
        ST_SUM,
        ST_MOD,
        ST_SCAN,
        ST_BAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_year;
        logic div_base;
        logic sum;
        logic mod7;
        logic scan_step;
        logic emit_bad;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad_month;
        logic weekend;
        logic last_day;
        logic out_free;
    } status_t;

    // days in a month outside february
    function automatic logic [DAY_W-1:0] base_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(31 * shifted_month / 12), shifted so that march is 1
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] off;
        case (month)
            4'd1:    off = 5'd28;
            4'd2:    off = 5'd31;
            4'd3:    off = 5'd2;
            4'd4:    off = 5'd5;
            4'd5:    off = 5'd7;
            4'd6:    off = 5'd10;
            4'd7:    off = 5'd12;
            4'd8:    off = 5'd15;
            4'd9:    off = 5'd18;
            4'd10:   off = 5'd20;
            4'd11:   off = 5'd23;
            4'd12:   off = 5'd25;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

FILE: rtl/core/wde_ctrl.sv
// controller state machine sequencing setup, day scan and bad-month result
module wde_ctrl
    import wde_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV_YEAR;
                end
            end
            ST_DIV_YEAR: begin
                cmd.div_year = 1'b1;
                state_next   = status.bad_month ? ST_BAD : ST_DIV_BASE;
            end
            ST_DIV_BASE: begin
                cmd.div_base = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd.mod7   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // a weekend day waits for a free output slot
                if (!status.weekend || status.out_free) begin
                    cmd.scan_step = 1'b1;
                    if (status.last_day) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD: begin
                if (status.out_free) begin
                    cmd.emit_bad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/wde_dp.sv
// datapath: weekday arithmetic, day counter and output register
module wde_dp
    import wde_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  in_item_t  s_data,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [B_W-1:0]     b_reg;
    logic [Q_W-1:0]     qy_reg;
    logic [Q_W-1:0]     qb_reg;
    logic [B_W-1:0]     sum_reg;
    logic [DAY_W-1:0]   len_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [WD_W-1:0]    wd_reg;
    logic               wsm_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg;

    logic               early;
    logic [B_W-1:0]     mul_a;
    logic [K_W-1:0]     mul_k;
    logic [PROD_W-1:0]  prod;
    logic [Q7_W-1:0]    q7;
    logic [WD_W-1:0]    wd_first;
    logic [6:0]         y_rem100;
    logic               div100, leap;
    logic [DAY_W-1:0]   len_calc;
    logic [B_W-1:0]     sum_calc;
    logic               weekend, last_day, last_weekend, out_free;
    logic [DAY_W:0]     next_sunday_plus;
    logic [WD_W-1:0]    shown;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsm_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            wsm_reg <= cfg_wr_data;
        end
    end

    // january and february count as months of the previous year
    assign early = (s_data.month < MONTH_MAR);

    // shared reciprocal multiplier for the divisions by 100 and by 7
    always_comb begin
        mul_a = b_reg;
        mul_k = K100;
        if (cmd.div_year) begin
            mul_a = B_W'(year_reg);
        end else if (cmd.mod7) begin
            mul_a = sum_reg;
            mul_k = K7;
        end
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_k);
    assign q7   = prod[SHIFT7 +: Q7_W];

    // remainder mod 7 only needs the low three bits
    assign wd_first = sum_reg[WD_W-1:0] - WD_W'(q7 * 3'd7);

    // leap year and month length
    assign y_rem100 = 7'(year_reg - YEAR_W'(qy_reg) * YEAR_W'(100));
    assign div100   = (y_rem100 == 7'd0);
    assign leap     = div100 ? (qy_reg[1:0] == 2'd0) : (year_reg[1:0] == 2'd0);
    assign len_calc = (month_reg == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : base_len(month_reg);

    // weekday sum for the first of the month
    assign sum_calc = B_W'(1) + B_W'(month_offset(month_reg)) + b_reg + (b_reg >> 2)
                    - B_W'(qb_reg) + B_W'(qb_reg >> 2);

    // scan status
    assign weekend          = (wd_reg == WD_SUN) || (wd_reg == WD_SAT);
    assign last_day         = (day_reg == len_reg);
    assign next_sunday_plus = {1'b0, day_reg} + 6'd6;
    assign last_weekend     = (wd_reg == WD_SAT) ? last_day
                                                 : (next_sunday_plus > {1'b0, len_reg});
    assign shown            = (wsm_reg) ? ((wd_reg == WD_SUN) ? 3'd6 : wd_reg - 3'd1) : wd_reg;
    assign out_free         = !m_valid_reg || m_ready;

    assign status.bad_month = (month_reg == '0) || (month_reg > MONTH_DEC);
    assign status.weekend   = weekend;
    assign status.last_day  = last_day;
    assign status.out_free  = out_free;

    // setup and scan registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            year_reg  <= s_data.year;
            month_reg <= s_data.month;
            b_reg     <= B_W'(s_data.year) + YEAR_BIAS - B_W'(early);
        end
        if (cmd.div_year) begin
            qy_reg <= prod[SHIFT100 +: Q_W];
        end
        if (cmd.div_base) begin
            qb_reg <= prod[SHIFT100 +: Q_W];
        end
        if (cmd.sum) begin
            sum_reg <= sum_calc;
            len_reg <= len_calc;
        end
        if (cmd.mod7) begin
            day_reg <= 5'd1;
            wd_reg  <= wd_first;
        end else if (cmd.scan_step) begin
            day_reg <= day_reg + 5'd1;
            wd_reg  <= (wd_reg == WD_SAT) ? WD_SUN : wd_reg + 3'd1;
        end
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if ((cmd.scan_step && weekend) || cmd.emit_bad) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_bad) begin
            m_data_reg <= '{day: '0, weekday: '0, month_length: '0, bad_month: 1'b1,
                            last: 1'b1};
        end else if (cmd.scan_step && weekend) begin
            m_data_reg <= '{day: day_reg, weekday: shown, month_length: len_reg,
                            bad_month: 1'b0, last: last_weekend};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a bad-month result is always the only one
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.bad_month |-> m_data_reg.last)
        else $error("bad-month result without last flag");

    // scan never runs past the month end and the weekday stays in range
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (day_reg <= len_reg) && (wd_reg <= WD_SAT) && (len_reg >= 5'd28))
        else $error("day scan out of range");

    // a weekend step always leaves a result in the output register
    a_weekend_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step && weekend |=> m_valid_reg && !m_data_reg.bad_month)
        else $error("weekend day not captured");

    // the scan only overwrites the output register when it is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && weekend) || cmd.emit_bad |-> out_free)
        else $error("pending result overwritten");

endmodule

FILE: rtl/core/weekend_day_enumerator.sv
// top level of the weekend day enumerator: controller plus datapath
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   in_item_t  {year, month}
//  m_        out        m_valid / m_ready   out_item_t {day, weekday, month_length,
//                                                       bad_month, last}
//  cfg_      in         cfg_wr_en           cfg_wr_data (week_starts_monday)
//
// a valid month runs four setup steps (year divide, base divide, sum, mod 7), three
// of them through the shared reciprocal multiplier, then scans one day per cycle when not paused
// a bad month gives one result
// the scan pauses on a weekend day while the output register holds an untaken result
// reset is synchronous and active low; it clears the controller, output valid
// and the configuration bit
module weekend_day_enumerator
    import wde_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t    cmd;
    status_t status;

    // sequencing
    wde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and output register
    wde_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
